// ===== hw/rtl/rme_pkg.sv =====
// Package for the rotation matrix to Z-Y-X Euler angle block.
// Holds widths, cell payload types, the arctangent table and the helper functions.
// Depends on nothing.
`default_nettype none
package rme_pkg;

	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;

	// Operand width of the CORDIC datapath: 32-bit operands plus gain growth and sign.
	localparam int CW = 36;

	typedef logic [ANGLE_BITS-1:0] ang_t;
	typedef logic signed [CW-1:0]  opd_t;

	typedef struct packed {
		logic signed [15:0] r11;
		logic signed [15:0] r21;
		logic signed [15:0] r31;
		logic signed [15:0] r32;
		logic signed [15:0] r33;
	} pose_t;

	// Word handed from one square root cell to the next.
	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] root;
		pose_t       pose;
	} sqrt_t;

	// Word handed from one CORDIC cell to the next.
	typedef struct packed {
		opd_t x;
		opd_t y;
		ang_t z;
		logic fix;
	} cor_t;

	localparam ang_t QUARTER = ang_t'(1) << (ANGLE_BITS - 2);
	localparam ang_t HALF    = ang_t'(1) << (ANGLE_BITS - 1);

	localparam int TAB_SH   = 32 - ANGLE_BITS;
	localparam int TAB_SHM1 = (TAB_SH > 0) ? TAB_SH - 1 : 0;
	localparam int OUT_DN   = (ANGLE_BITS > 16) ? ANGLE_BITS - 17 : 0;
	localparam int OUT_UP   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

	// atan(2^-i) in units of 2^32 per turn.
	function automatic logic [31:0] atan_turn32(input logic [4:0] i);
		logic [31:0] t;
		case (i)
			5'd0:  t = 32'h20000000;
			5'd1:  t = 32'h12E4051E;
			5'd2:  t = 32'h09FB385B;
			5'd3:  t = 32'h051111D4;
			5'd4:  t = 32'h028B0D43;
			5'd5:  t = 32'h0145D7E1;
			5'd6:  t = 32'h00A2F61E;
			5'd7:  t = 32'h00517C55;
			5'd8:  t = 32'h0028BE53;
			5'd9:  t = 32'h00145F2F;
			5'd10: t = 32'h000A2F98;
			5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6;
			5'd13: t = 32'h000145F3;
			5'd14: t = 32'h0000A2FA;
			5'd15: t = 32'h0000517D;
			5'd16: t = 32'h000028BE;
			5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30;
			5'd19: t = 32'h00000518;
			5'd20: t = 32'h0000028C;
			5'd21: t = 32'h00000146;
			5'd22: t = 32'h000000A3;
			5'd23: t = 32'h00000051;
			5'd24: t = 32'h00000029;
			5'd25: t = 32'h00000014;
			5'd26: t = 32'h0000000A;
			5'd27: t = 32'h00000005;
			5'd28: t = 32'h00000003;
			5'd29: t = 32'h00000001;
			5'd30: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

	// Table entry rounded to the accumulator width.
	function automatic ang_t atan_entry(input logic [4:0] i);
		logic [32:0] u;
		u = ({1'b0, atan_turn32(i)} >> TAB_SHM1) + 33'd1;
		if (TAB_SH == 0) begin
			return ang_t'(atan_turn32(i));
		end
		return ang_t'(u >> 1);
	endfunction

	// Special cases and the quarter turn for the left half plane.
	function automatic cor_t cor_prep(input opd_t y, input opd_t x);
		cor_t c;
		c.x   = x;
		c.y   = y;
		c.z   = '0;
		c.fix = 1'b0;
		if (y == '0) begin
			c.fix = 1'b1;
			c.z   = x[CW-1] ? HALF : '0;
		end else if (x == '0) begin
			c.fix = 1'b1;
			c.z   = y[CW-1] ? ang_t'(-QUARTER) : QUARTER;
		end else if (x[CW-1]) begin
			if (!y[CW-1]) begin
				c.x = y;
				c.y = -x;
				c.z = QUARTER;
			end else begin
				c.x = -y;
				c.y = x;
				c.z = ang_t'(-QUARTER);
			end
		end
		return c;
	endfunction

	// Accumulator angle to a 16-bit binary angle.
	function automatic logic [15:0] to_bam16(input ang_t z);
		logic [ANGLE_BITS:0] u;
		u = ({1'b0, z} >> OUT_DN) + (ANGLE_BITS+1)'(1);
		if (ANGLE_BITS > 16) begin
			return 16'(u >> 1);
		end
		return 16'(z) << OUT_UP;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_euler_zyx.sv =====
// Top level: rotation matrix entries in, Z-Y-X Euler angles out.
// Depends on rme_pkg, rme_sqrt_cell and rme_cordic_cell.
//
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | r11 r21 r31 r32 r33 (Q1.14)
//  out     | out_valid / out_ready | roll_angle pitch_angle yaw_angle (32768 = pi)
//
// One word enters per cycle while the output is not stalled; a word passes through a squaring
// stage, 32 square root cells, a setup stage, the CORDIC cells and the output register.
// Reset clears only the valid bits of the chain.
// A stall at the output freezes the whole chain; a bubble moves on, so an empty
// output register lets the chain advance.
`default_nettype none
module rotation_matrix_to_euler_zyx (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] r11,
	input  wire logic signed [15:0] r21,
	input  wire logic signed [15:0] r31,
	input  wire logic signed [15:0] r32,
	input  wire logic signed [15:0] r33,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      roll_angle,
	output logic signed [15:0]      pitch_angle,
	output logic signed [15:0]      yaw_angle
);
	import rme_pkg::*;

	localparam int NV = CORDIC_STAGES + 35;

	logic          adv;
	logic [NV-1:0] vld_q;
	sqrt_t         sq_s [33];
	cor_t          roll_s  [CORDIC_STAGES+1];
	cor_t          pitch_s [CORDIC_STAGES+1];
	cor_t          yaw_s   [CORDIC_STAGES+1];
	logic [31:0]   sum_sq;
	logic signed [15:0] pitch_raw;

	assign adv      = !vld_q[NV-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[NV-1];

	// Valid bits shift along with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NV-2:0], in_valid};
		end
	end

	// Squaring stage feeds the square root chain with (r32^2 + r33^2) * 2^32.
	assign sum_sq = 32'(r32 * r32) + 32'(r33 * r33);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].rem  <= {sum_sq, 32'd0};
			sq_s[0].root <= '0;
			sq_s[0].pose <= '{r11: r11, r21: r21, r31: r31, r32: r32, r33: r33};
		end
	end

	// Square root cells, most significant root bit first.
	for (genvar j = 0; j < 32; j++) begin : g_sqrt
		rme_sqrt_cell u_cell (
			.clk  (clk),
			.en   (adv),
			.idx  (5'(31 - j)),
			.din  (sq_s[j]),
			.dout (sq_s[j+1])
		);
	end

	// Setup stage for the three arctangent lanes.
	always_ff @(posedge clk) begin
		if (adv) begin
			roll_s[0]  <= cor_prep(opd_t'(sq_s[32].pose.r32) <<< 16,
				opd_t'(sq_s[32].pose.r33) <<< 16);
			pitch_s[0] <= cor_prep(-(opd_t'(sq_s[32].pose.r31) <<< 16),
				opd_t'({4'd0, sq_s[32].root}));
			yaw_s[0]   <= cor_prep(opd_t'(sq_s[32].pose.r21) <<< 16,
				opd_t'(sq_s[32].pose.r11) <<< 16);
		end
	end

	// CORDIC cells of the three lanes.
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cor
		rme_cordic_cell u_roll (
			.clk  (clk),
			.en   (adv),
			.idx  (5'(k)),
			.din  (roll_s[k]),
			.dout (roll_s[k+1])
		);
		rme_cordic_cell u_pitch (
			.clk  (clk),
			.en   (adv),
			.idx  (5'(k)),
			.din  (pitch_s[k]),
			.dout (pitch_s[k+1])
		);
		rme_cordic_cell u_yaw (
			.clk  (clk),
			.en   (adv),
			.idx  (5'(k)),
			.din  (yaw_s[k]),
			.dout (yaw_s[k+1])
		);
	end

	assign pitch_raw = signed'(to_bam16(pitch_s[CORDIC_STAGES].z));

	// Output register: rounding to 16 bits and the pitch clamp.
	always_ff @(posedge clk) begin
		if (adv) begin
			roll_angle <= signed'(to_bam16(roll_s[CORDIC_STAGES].z));
			yaw_angle  <= signed'(to_bam16(yaw_s[CORDIC_STAGES].z));
			if (pitch_raw > 16'sd16384) begin
				pitch_angle <= 16'sd16384;
			end else if (pitch_raw < -16'sd16384) begin
				pitch_angle <= -16'sd16384;
			end else begin
				pitch_angle <= pitch_raw;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rme_sqrt_cell.sv =====
// One cell of the pipelined integer square root: settles one root bit.
// Depends on rme_pkg.
`default_nettype none
module rme_sqrt_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [4:0]    idx,
	input  wire rme_pkg::sqrt_t din,
	output rme_pkg::sqrt_t      dout
);
	import rme_pkg::*;

	logic [63:0] trial;

	// Try setting the root bit: (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k).
	assign trial = ({32'd0, din.root} << (idx + 6'd1)) + (64'd1 << {idx, 1'b0});

	always_ff @(posedge clk) begin
		if (en) begin
			dout.pose <= din.pose;
			if (din.rem >= trial) begin
				dout.rem  <= din.rem - trial;
				dout.root <= din.root | (32'd1 << idx);
			end else begin
				dout.rem  <= din.rem;
				dout.root <= din.root;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rme_cordic_cell.sv =====
// One vectoring CORDIC cell: a single micro-rotation toward the x axis.
// Depends on rme_pkg.
`default_nettype none
module rme_cordic_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [4:0]    idx,
	input  wire rme_pkg::cor_t din,
	output rme_pkg::cor_t      dout
);
	import rme_pkg::*;

	opd_t xs;
	opd_t ys;

	assign xs = din.x >>> idx;
	assign ys = din.y >>> idx;

	// Words resolved up front pass through untouched.
	always_ff @(posedge clk) begin
		if (en) begin
			dout.fix <= din.fix;
			if (din.fix) begin
				dout.x <= din.x;
				dout.y <= din.y;
				dout.z <= din.z;
			end else if (!din.y[CW-1]) begin
				dout.x <= din.x + ys;
				dout.y <= din.y - xs;
				dout.z <= din.z + atan_entry(idx);
			end else begin
				dout.x <= din.x - ys;
				dout.y <= din.y + xs;
				dout.z <= din.z - atan_entry(idx);
			end
		end
	end

endmodule
`default_nettype wire

// ===== dv/euler_zyx_checker.sv =====
// Checker for the rotation matrix to Z-Y-X Euler angle block.
// Watches both channels, computes the expected angles and compares them.
// Depends on nothing but the ports of the block.
`timescale 1ns / 100ps
module euler_zyx_checker (
	input  wire logic               clk,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic signed [15:0] r11,
	input  wire logic signed [15:0] r21,
	input  wire logic signed [15:0] r31,
	input  wire logic signed [15:0] r32,
	input  wire logic signed [15:0] r33,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [15:0] roll_angle,
	input  wire logic signed [15:0] pitch_angle,
	input  wire logic signed [15:0] yaw_angle,
	output int                      errors,
	output int                      pending
);
	localparam int ABITS  = 16;
	localparam int STAGES = 16;

	typedef struct {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
	} angles_t;

	angles_t angle_queue[$];

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic longint unsigned atan_step(int i);
		longint unsigned t[32] = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
			32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
			32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
			32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
		int sh;
		sh = 32 - ABITS;
		if (sh == 0) return t[i];
		return ((t[i] >> (sh - 1)) + 1) >> 1;
	endfunction

	// Vectoring arctangent, result as a binary angle of ABITS bits.
	function automatic longint unsigned vec_atan2(longint y, longint x);
		longint unsigned msk, qtr, z;
		longint t, xs, ys;
		msk = (64'd1 << ABITS) - 1;
		qtr = 64'd1 << (ABITS - 2);
		z = 0;
		if (y == 0) return (x < 0) ? 2 * qtr : 0;
		if (x == 0) return (y > 0) ? qtr : ((0 - qtr) & msk);
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = qtr;
			end else begin
				t = x; x = -y; y = t; z = (0 - qtr) & msk;
			end
		end
		for (int i = 0; i < STAGES && i < 32; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = (z + atan_step(i)) & msk;
			end else begin
				x = x - ys; y = y + xs; z = (z - atan_step(i)) & msk;
			end
		end
		return z;
	endfunction

	function automatic logic [15:0] to_angle16(longint unsigned z);
		int sh;
		if (ABITS >= 16) begin
			sh = ABITS - 16;
			if (sh == 0) return z[15:0];
			return 16'(((z >> (sh - 1)) + 1) >> 1);
		end
		return 16'(z << (16 - ABITS));
	endfunction

	// Exact integer square root.
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic angles_t euler_of(longint a11, longint a21, longint a31,
		longint a32, longint a33);
		angles_t e;
		longint mag;
		logic signed [15:0] p;
		mag = longint'(int_sqrt(longint'(a32 * a32 + a33 * a33) << 32));
		e.roll = to_angle16(vec_atan2(a32 * 65536, a33 * 65536));
		p = to_angle16(vec_atan2(-a31 * 65536, mag));
		if (p > 16384) p = 16384;
		if (p < -16384) p = -16384;
		e.pitch = p;
		e.yaw = to_angle16(vec_atan2(a21 * 65536, a11 * 65536));
		return e;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	// Predict on every accepted input word, compare on every accepted output word.
	always @(posedge clk) begin
		angles_t e;
		if (in_valid && in_ready) begin
			angle_queue.push_back(euler_of(r11, r21, r31, r32, r33));
		end
		if (out_valid && out_ready) begin
			if (angle_queue.size() == 0) begin
				$display("%0t: unexpected word %h %h %h", $time,
					roll_angle, pitch_angle, yaw_angle);
				errors++;
			end else begin
				e = angle_queue.pop_front();
				if (roll_angle !== e.roll) begin
					$display("%0t: roll exp %h got %h", $time, e.roll, roll_angle);
					errors++;
				end
				if (pitch_angle !== e.pitch) begin
					$display("%0t: pitch exp %h got %h", $time, e.pitch, pitch_angle);
					errors++;
				end
				if (yaw_angle !== e.yaw) begin
					$display("%0t: yaw exp %h got %h", $time, e.yaw, yaw_angle);
					errors++;
				end
			end
		end
		pending <= angle_queue.size();
	end
endmodule

// ===== dv/tb_rotation_matrix_to_euler_zyx.sv =====
// Testbench top for the rotation matrix to Z-Y-X Euler angle block.
// Drives directed and random matrix entries with random gaps and stalls.
// Depends on rotation_matrix_to_euler_zyx and euler_zyx_checker.
`timescale 1ns / 100ps
module tb_rotation_matrix_to_euler_zyx;
	localparam int LATENCY = 51;
	localparam int CYCLE_LIMIT = 200000;

	logic clk, arst_n, in_valid, out_ready, out_valid, in_ready;
	logic signed [15:0] r11, r21, r31, r32, r33;
	logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
	int errors, pending, cycles;

	rotation_matrix_to_euler_zyx dut (.*);

	euler_zyx_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Cycle limit as a guard against a hung pipeline.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL rotation_matrix_to_euler_zyx");
				$finish;
			end
		end
	end

	// Receiver: random stalls, with a stretch of none.
	initial begin
		int w;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = (cycles % 3000 < 600) ? 0 : $urandom_range(0, 4);
			if (w == 0) begin
				out_ready = 1;
			end else begin
				out_ready = 0;
				repeat (w - 1) @(negedge clk);
			end
		end
	end

	// One word: optional gap, then hold valid until accepted.
	task automatic send_word(logic signed [15:0] a, b, c, d, e, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 4) : 0;
		if (w > 0) begin
			in_valid = 0;
			repeat (w) @(negedge clk);
		end
		in_valid = 1;
		{r11, r21, r31, r32, r33} = {a, b, c, d, e};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(0, 9))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	initial begin
		logic signed [15:0] v[5];
		logic signed [15:0] m, n;
		real th;
		bit gaps;
		arst_n = 0;
		in_valid = 0;
		{r11, r21, r31, r32, r33} = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Directed: zeros, axes, the plus pi wrap, left half plane, extremes.
		send_word(0, 0, 0, 0, 0, 0);
		send_word(16384, 0, 0, 0, 16384, 0);
		send_word(-16384, 0, 0, 0, -16384, 0);
		send_word(0, 16384, 16384, 16384, 0, 0);
		send_word(0, -16384, -16384, -16384, 0, 0);
		send_word(-16384, 1, 16384, 1, -16384, 0);
		send_word(-16384, -1, -16384, -1, -16384, 0);
		send_word(11585, 11585, -11585, 11585, 11585, 0);
		send_word(-11585, 11585, 11585, -11585, -11585, 0);
		send_word(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
		send_word(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 0);
		send_word(16'sh7FFF, -16'sh8000, 16'sh5555, -16'sh8000, 16'sh7FFF, 0);
		send_word(1, -1, 1, -1, 1, 0);
		send_word(16384, 0, 16384, 0, 0, 0);
		send_word(16384, 0, -16384, 0, 0, 0);
		// Random: mostly rotation-like entries, the rest any 16-bit values.
		for (int k = 0; k < 450; k++) begin
			gaps = (k % 150) >= 40;
			if ($urandom_range(0, 3) != 0) begin
				th = ($urandom_range(0, 65535) / 65536.0) * 6.2831853;
				m = 16'($rtoi(16384.0 * $cos(th)));
				n = 16'($rtoi(16384.0 * $sin(th)));
				v[0] = m; v[1] = n;
				th = ($urandom_range(0, 65535) / 65536.0) * 6.2831853;
				v[2] = 16'($rtoi(16384.0 * $sin(th)));
				v[3] = 16'($rtoi(16384.0 * $cos(th) * 0.7));
				v[4] = 16'($rtoi(16384.0 * $cos(th) * -0.7));
			end else begin
				foreach (v[j]) v[j] = rand_entry();
			end
			send_word(v[0], v[1], v[2], v[3], v[4], gaps);
		end
		in_valid = 0;
		while (pending != 0 || u_chk.angle_queue.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS rotation_matrix_to_euler_zyx");
		end else begin
			$display("FAIL rotation_matrix_to_euler_zyx");
		end
		$finish;
	end
endmodule
